### rtl/core/fre_pkg.sv
// Package for the four-register ALU execute unit.
// Holds the operation codes, the opcode map reset value and operand decode helpers.
// No dependencies.
`timescale 1ns / 1ps

package fre_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned OperW  = 16;
  localparam int unsigned FuncW  = 4;
  localparam int unsigned MapW   = 64;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned RegIdxW = $clog2(NumRegs);

  localparam logic [MapW-1:0] OpcodeMapReset = 64'h79B1_AD40_563C_F8E2;

  typedef enum logic [3:0] {
    OpAddr = 4'd0,
    OpAddi = 4'd1,
    OpMulr = 4'd2,
    OpMuli = 4'd3,
    OpBanr = 4'd4,
    OpBani = 4'd5,
    OpBorr = 4'd6,
    OpBori = 4'd7,
    OpSetr = 4'd8,
    OpSeti = 4'd9,
    OpGtir = 4'd10,
    OpGtri = 4'd11,
    OpGtrr = 4'd12,
    OpEqir = 4'd13,
    OpEqri = 4'd14,
    OpEqrr = 4'd15
  } alu_op_e;

  // First operand is a register index unless the operation takes it as an immediate.
  function automatic logic a_is_reg(alu_op_e op);
    return !(op == OpSeti || op == OpGtir || op == OpEqir);
  endfunction

  function automatic logic b_is_reg(alu_op_e op);
    return (op == OpAddr || op == OpMulr || op == OpBanr || op == OpBorr ||
            op == OpGtir || op == OpGtrr || op == OpEqir || op == OpEqrr);
  endfunction

endpackage

### rtl/core/four_register_alu_execute_unit.sv
// Top level of the four-register ALU execute unit: input register, ALU and register file.
// Depends on fre_pkg for operation codes and operand decode.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o  | func_i, a_i, b_i, c_i
//   out     | output    | out_valid_o/out_ready_i| reg0_o..reg3_o, bad_operand_o
//   cfg     | input     | cfg_we_i (no wait)     | cfg_wdata_i (opcode map)
//
// One instruction is retired per cycle while the output is not stalled. An instruction passes
// from the input register through the ALU with its 32x32 multiplier, which writes the register
// file, and the register file drives the result ports directly.
// Reset clears the register file, the valid flags and loads the default opcode map.
// When the output stalls, one more instruction is held in the input register.
`timescale 1ns / 1ps

module four_register_alu_execute_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fre_pkg::MapW-1:0]          cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fre_pkg::FuncW-1:0]         func_i,
  input  logic [fre_pkg::OperW-1:0]         a_i,
  input  logic [fre_pkg::OperW-1:0]         b_i,
  input  logic [fre_pkg::RegIdxW-1:0]       c_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [fre_pkg::DataW-1:0]  reg0_o,
  output logic signed [fre_pkg::DataW-1:0]  reg1_o,
  output logic signed [fre_pkg::DataW-1:0]  reg2_o,
  output logic signed [fre_pkg::DataW-1:0]  reg3_o,
  output logic                              bad_operand_o
);
  import fre_pkg::*;

  logic [MapW-1:0]    map_q;
  logic               in_vld_q;
  logic [FuncW-1:0]   func_q;
  logic [OperW-1:0]   a_q;
  logic [OperW-1:0]   b_q;
  logic [RegIdxW-1:0] c_q;
  logic               out_vld_q;
  logic               bad_q;
  logic [DataW-1:0]   rf_q [NumRegs];

  logic               ex_fire;
  alu_op_e            op;
  logic               bad_d;
  logic [DataW-1:0]   ra;
  logic [DataW-1:0]   rb;
  logic [DataW-1:0]   imm_a;
  logic [DataW-1:0]   imm_b;
  logic [DataW-1:0]   res_d;

  assign ex_fire    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || ex_fire;

  assign op    = alu_op_e'(map_q[{func_q, 2'b00} +: 4]);
  assign bad_d = (a_is_reg(op) && (a_q[OperW-1:RegIdxW] != '0)) ||
                 (b_is_reg(op) && (b_q[OperW-1:RegIdxW] != '0));
  assign ra    = rf_q[a_q[RegIdxW-1:0]];
  assign rb    = rf_q[b_q[RegIdxW-1:0]];
  assign imm_a = {{(DataW-OperW){1'b0}}, a_q};
  assign imm_b = {{(DataW-OperW){1'b0}}, b_q};

  always_comb begin
    unique case (op)
      OpAddr: res_d = ra + rb;
      OpAddi: res_d = ra + imm_b;
      OpMulr: res_d = ra * rb;
      OpMuli: res_d = ra * imm_b;
      OpBanr: res_d = ra & rb;
      OpBani: res_d = ra & imm_b;
      OpBorr: res_d = ra | rb;
      OpBori: res_d = ra | imm_b;
      OpSetr: res_d = ra;
      OpSeti: res_d = imm_a;
      OpGtir: res_d = {{(DataW-1){1'b0}}, ($signed(imm_a) > $signed(rb))};
      OpGtri: res_d = {{(DataW-1){1'b0}}, ($signed(ra) > $signed(imm_b))};
      OpGtrr: res_d = {{(DataW-1){1'b0}}, ($signed(ra) > $signed(rb))};
      OpEqir: res_d = {{(DataW-1){1'b0}}, (imm_a == rb)};
      OpEqri: res_d = {{(DataW-1){1'b0}}, (ra == imm_b)};
      OpEqrr: res_d = {{(DataW-1){1'b0}}, (ra == rb)};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= OpcodeMapReset;
    end else if (cfg_we_i) begin
      map_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      a_q    <= a_i;
      b_q    <= b_i;
      c_q    <= c_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      bad_q     <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      if (ex_fire) begin
        out_vld_q <= 1'b1;
        bad_q     <= bad_d;
        if (!bad_d) begin
          rf_q[c_q] <= res_d;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // The register file only changes on an execute transfer, so it can drive the result directly.
  assign out_valid_o   = out_vld_q;
  assign reg0_o        = rf_q[0];
  assign reg1_o        = rf_q[1];
  assign reg2_o        = rf_q[2];
  assign reg3_o        = rf_q[3];
  assign bad_operand_o = bad_q;

  a_rf_stable_without_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_fire |=> (rf_q[0] == $past(rf_q[0])) && (rf_q[1] == $past(rf_q[1])) &&
                 (rf_q[2] == $past(rf_q[2])) && (rf_q[3] == $past(rf_q[3])))
    else $error("Register file changed without an execute transfer.");

  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire && bad_d |=> (rf_q[0] == $past(rf_q[0])) && (rf_q[1] == $past(rf_q[1])) &&
                         (rf_q[2] == $past(rf_q[2])) && (rf_q[3] == $past(rf_q[3])))
    else $error("Register file written by an instruction with a bad operand.");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire |=> $countones({rf_q[0] != $past(rf_q[0]), rf_q[1] != $past(rf_q[1]),
                            rf_q[2] != $past(rf_q[2]), rf_q[3] != $past(rf_q[3])}) <= 1)
    else $error("More than one register written by one instruction.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("Input stalled while the execute stage could advance.");

endmodule
